>>> src/bbcd_pkg.sv
// ============================================================================
// bbcd_pkg - block buffer cache directory shared definitions
// Types, sizes and codes used by the controller, datapath and top level.
// ============================================================================
package bbcd_pkg;

    localparam int NUM_BUFFERS = 32;
    localparam int REF_BITS    = 8;
    localparam int IDX_W       = $clog2(NUM_BUFFERS);

    // Fixed field widths of the stream words
    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;

    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    typedef enum logic [1:0] {
        REQ_GET     = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_PIN     = 2'd2,
        REQ_UNPIN   = 2'd3
    } req_e_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_e_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET_RD,
        S_GET_WAIT,
        S_GET_WR,
        S_OP_RD,
        S_OP_WR
    } state_e_t;

    // One directory entry
    typedef struct packed {
        logic [7:0]          dev;
        logic [31:0]         blk;
        logic [REF_BITS-1:0] refc;
        logic [31:0]         luse;
        logic                fill;
    } entry_t;

    // Captured request word
    typedef struct packed {
        req_e_t      rtype;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [4:0]  idx;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [4:0] granted_index;
        logic       hit;
        logic       needs_fill;
        status_e_t  status;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_rd;
        logic op_rd;
        logic get_fin;
        logic op_fin;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
    } sts_t;

endpackage

>>> src/bbcd_ctrl.sv
// ============================================================================
// bbcd_ctrl - request sequencer
// Steps a request through scan or single-entry read, then the write-back.
// ============================================================================
module bbcd_ctrl
    import bbcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_is_get,
    input  logic out_free,
    input  sts_t sts,
    output logic in_ready,
    output cmd_t cmd
);

    state_e_t state_reg;
    state_e_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_is_get ? S_GET_RD : S_OP_RD;
                end
            end
            S_GET_RD:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_GET_WAIT;
                end
            end
            S_GET_WAIT:
            begin
                state_next = S_GET_WR;
            end
            S_GET_WR:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_OP_RD:
            begin
                state_next = S_OP_WR;
            end
            S_OP_WR:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load     = in_valid;
                cmd.scan_clr = in_valid;
            end
            S_GET_RD:
            begin
                cmd.scan_rd = 1'b1;
            end
            S_GET_WR:
            begin
                cmd.get_fin = out_free;
            end
            S_OP_RD:
            begin
                cmd.op_rd = 1'b1;
            end
            S_OP_WR:
            begin
                cmd.op_fin = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/bbcd_dpath.sv
// ============================================================================
// bbcd_dpath - directory storage and search datapath
// Entry memory with valid bits, scan pipeline, victim choice and write-back.
// ============================================================================
module bbcd_dpath
    import bbcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  req_e_t      in_rtype,
    input  logic [7:0]  in_dev,
    input  logic [31:0] in_blk,
    input  logic [4:0]  in_idx,
    input  logic [31:0] in_now,
    output sts_t        sts,
    output result_t     res
);

    entry_t ent_mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] valid_reg;

    req_t             req_reg;
    logic [IDX_W-1:0] scan_cnt_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    entry_t           rd_ent_reg;
    logic             rd_vld_reg;
    logic             cmp_reg;

    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    entry_t           match_ent_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_time_reg;

    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] req_addr;
    entry_t           e;
    logic             e_match;
    logic             e_better;
    logic             in_range;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;

    assign req_addr      = IDX_W'(req_reg.idx);
    assign raddr         = cmd.scan_rd ? scan_cnt_reg : req_addr;
    assign sts.scan_last = (scan_cnt_reg == IDX_W'(NUM_BUFFERS - 1));
    assign in_range      = (32'(req_reg.idx) < NUM_BUFFERS);

    // Entries never written read as all zero
    assign e        = rd_vld_reg ? rd_ent_reg : '0;
    assign e_match  = (e.dev == req_reg.dev) && (e.blk == req_reg.blk);
    assign e_better = (e.refc == '0) && (!free_found_reg || (e.luse < best_time_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg.rtype <= in_rtype;
            req_reg.dev   <= in_dev;
            req_reg.blk   <= in_blk;
            req_reg.idx   <= in_idx;
            req_reg.now   <= in_now;
        end
        if (cmd.scan_rd || cmd.op_rd)
        begin
            rd_ent_reg <= ent_mem[raddr];
            rd_idx_reg <= raddr;
        end
        if (we)
        begin
            ent_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            cmp_reg      <= 1'b0;
            scan_cnt_reg <= '0;
        end
        else
        begin
            cmp_reg <= cmd.scan_rd;
            if (cmd.scan_rd || cmd.op_rd)
            begin
                rd_vld_reg <= valid_reg[raddr];
            end
            if (cmd.scan_clr)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    // Scan compare: first match and oldest free entry, ties to lowest index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (cmd.scan_clr)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (cmp_reg)
        begin
            if (e_match)
            begin
                match_found_reg <= 1'b1;
            end
            if (e_better)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_reg)
        begin
            if (e_match && !match_found_reg)
            begin
                match_idx_reg <= rd_idx_reg;
                match_ent_reg <= e;
            end
            if (e_better)
            begin
                best_idx_reg  <= rd_idx_reg;
                best_time_reg <= e.luse;
            end
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = req_addr;
        wdata = e;
        res   = '0;
        if (cmd.get_fin)
        begin
            if (match_found_reg)
            begin
                res.granted_index = 5'(match_idx_reg);
                res.hit           = 1'b1;
                if (match_ent_reg.refc == REF_MAX)
                begin
                    res.status = ST_OVERFLOW;
                end
                else
                begin
                    we             = 1'b1;
                    waddr          = match_idx_reg;
                    wdata          = match_ent_reg;
                    wdata.refc     = match_ent_reg.refc + 1'b1;
                    wdata.fill     = 1'b1;
                    res.needs_fill = !match_ent_reg.fill;
                end
            end
            else if (free_found_reg)
            begin
                we                = 1'b1;
                waddr             = best_idx_reg;
                wdata.dev         = req_reg.dev;
                wdata.blk         = req_reg.blk;
                wdata.refc        = REF_BITS'(1);
                wdata.luse        = best_time_reg;
                wdata.fill        = 1'b1;
                res.granted_index = 5'(best_idx_reg);
                res.needs_fill    = 1'b1;
            end
            else
            begin
                res.status = ST_NO_FREE;
            end
        end
        else if (cmd.op_fin)
        begin
            res.granted_index = req_reg.idx;
            if (in_range)
            begin
                case (req_reg.rtype)
                    REQ_PIN:
                    begin
                        if (e.refc == REF_MAX)
                        begin
                            res.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            we         = 1'b1;
                            wdata.refc = e.refc + 1'b1;
                        end
                    end
                    REQ_RELEASE, REQ_UNPIN:
                    begin
                        if (e.refc == '0)
                        begin
                            res.status = ST_UNDERFLOW;
                        end
                        else
                        begin
                            we         = 1'b1;
                            wdata.refc = e.refc - 1'b1;
                            // stamp last use when a release drops the final reference
                            if ((req_reg.rtype == REQ_RELEASE) &&
                                (e.refc == REF_BITS'(1)))
                            begin
                                wdata.luse = req_reg.now;
                            end
                        end
                    end
                    default:
                    begin
                        we = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

>>> src/block_buffer_cache_directory.sv
// ============================================================================
// block_buffer_cache_directory - LRU block buffer cache directory
// Tag, reference count and last-use directory for a fixed buffer pool, with
// a registered result stage in front of the master stream.
// ============================================================================
//
//  channel  dir  tdata fields (low bit up)                       tuser
//  -------  ---  ----------------------------------------------  --------
//  s_*      in   device, block_number, buffer_index, now (80b)  req_type
//  m_*      out  granted_index, hit, needs_fill, status (16b)   -
//
// A get accepts the word, reads each buffer in turn through the single read
// port of the entry memory, makes the last compare, then writes back. Release,
// pin and unpin accept the word, read the one entry, then write back.
// Reset clears per-entry valid bits at once; no clearing pass is needed.
// A stalled master side holds the finished result and the write-back until
// the output register frees up; the next word is taken only once idle.
//
module block_buffer_cache_directory
    import bbcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] device, [39:8] block_number, [44:40] buffer_index, [76:45] now
    input  logic [S_DATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [4:0] granted_index, [5] hit, [6] needs_fill, [8:7] status
    output logic [M_DATA_W-1:0] m_tdata
);

    cmd_t    cmd;
    sts_t    sts;
    result_t res;
    logic    out_free;
    logic    m_tvalid_reg;
    result_t m_res_reg;

    // Output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    bbcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_is_get (req_e_t'(s_tuser) == REQ_GET),
        .out_free  (out_free),
        .sts       (sts),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    bbcd_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_rtype (req_e_t'(s_tuser)),
        .in_dev   (s_tdata[7:0]),
        .in_blk   (s_tdata[39:8]),
        .in_idx   (s_tdata[44:40]),
        .in_now   (s_tdata[76:45]),
        .sts      (sts),
        .res      (res)
    );

    // Load the result word on finish, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.get_fin || cmd.op_fin)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.get_fin || cmd.op_fin)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_res_reg.status, m_res_reg.needs_fill,
                       m_res_reg.hit, m_res_reg.granted_index};

endmodule
